@@ hw/rtl/ctvp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctvp_pkg
// Shared types, constants and arithmetic helpers of the cascaded track /
// velocity PID block.
// ----------------------------------------------------------------------------
package ctvp_pkg;

    localparam int GAIN_FRAC_BITS  = 12;
    localparam int TRACK_SUM_LIMIT = 1000;
    localparam int SUM_DECLINE     = 20;
    localparam int CORRECTION_COEF = 2;
    localparam int ROTATE_COEF     = 5;
    localparam int STRAIGHT_COEF   = 1;

    // track error = deviation * coefficient (coefficient up to 15)
    localparam int TRK_E_W   = 20;
    localparam int TRK_D_W   = TRK_E_W + 1;
    localparam int SUM_W     = 17;
    localparam int TRK_ACC_W = 40;
    localparam int VEL_E_W   = 32;
    localparam int VEL_D_W   = 33;
    localparam int ACC_W     = 52;

    // register indexes
    localparam logic [2:0] REG_VEL_KP    = 3'd0;
    localparam logic [2:0] REG_VEL_KI    = 3'd1;
    localparam logic [2:0] REG_VEL_KD    = 3'd2;
    localparam logic [2:0] REG_VEL_LIMIT = 3'd3;
    localparam logic [2:0] REG_TRK_KP    = 3'd4;
    localparam logic [2:0] REG_TRK_KI    = 3'd5;
    localparam logic [2:0] REG_TRK_KD    = 3'd6;
    localparam logic [2:0] REG_CTRL_EN   = 3'd7;

    // track actions
    localparam logic [1:0] ACT_TENDENCY = 2'd0;
    localparam logic [1:0] ACT_TORQUE   = 2'd1;
    localparam logic [1:0] ACT_ROTATE   = 2'd2;
    localparam logic [1:0] ACT_STRAIGHT = 2'd3;

    // operations
    localparam logic OP_CONTROL = 1'b0;
    localparam logic OP_DECLINE = 1'b1;

    // lane operations
    localparam logic [1:0] LOP_RUN     = 2'd0;
    localparam logic [1:0] LOP_DECLINE = 2'd1;
    localparam logic [1:0] LOP_CLEAR   = 2'd2;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
    } t_gains;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        logic       ld;     // take the new target with this run
    } t_lane_cmd;

    typedef struct packed {
        logic start;
        logic clr;
    } t_trk_cmd;

    function automatic logic signed [31:0] f_sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -33'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] f_decay(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > SUM_W'(SUM_DECLINE))
            r = v - SUM_W'(SUM_DECLINE);
        else if (v < -SUM_W'(SUM_DECLINE))
            r = v + SUM_W'(SUM_DECLINE);
        else
            r = '0;
        return r;
    endfunction

    // divide by 2^GAIN_FRAC_BITS truncating toward zero, then saturate
    function automatic logic signed [31:0] f_scale_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] b;
        b = a[ACC_W-1] ? a + ACC_W'((1 << GAIN_FRAC_BITS) - 1) : a;
        b = b >>> GAIN_FRAC_BITS;
        if (b > ACC_W'(64'sd2147483647))
            return 32'sh7fffffff;
        else if (b < -ACC_W'(64'sd2147483648))
            return 32'sh80000000;
        else
            return b[31:0];
    endfunction

endpackage

@@ hw/rtl/cascaded_track_velocity_pid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_track_velocity_pid
// Track PID feeding two velocity PID lanes for a differential drive.
// ----------------------------------------------------------------------------
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_ready   | operation, speeds, track fields
// out     | output    | o_out_valid / i_out_ready | drive_left/right, correction
// cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One transaction at a time. A control step with the track loop running goes
// through dispatch, the track MAC, the target stage, the lane MACs and the
// output stage before the next ready. Track-off and straight steps skip the
// track MAC and target stage; declines and disabled steps skip the MACs.
// Synchronous active-low reset clears all loop state to zero.
// The next transaction is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module cascaded_track_velocity_pid
    import ctvp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic signed [15:0]  i_speed_left,
    input  logic signed [15:0]  i_speed_right,
    input  logic                i_track_enable,
    input  logic [1:0]          i_track_action,
    input  logic signed [15:0]  i_deviation_level,
    input  logic signed [15:0]  i_base_target_speed,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_drive_left,
    output logic signed [31:0]  o_drive_right,
    output logic signed [31:0]  o_track_correction
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_TRK  = 3'd2;
    localparam logic [2:0] S_TGT  = 3'd3;
    localparam logic [2:0] S_LANE = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;

    t_gains      r_vel_gains;
    t_gains      r_trk_gains;
    logic [15:0] r_vel_limit;
    logic        r_cen;

    logic [2:0]         r_state;
    logic               r_op;
    logic signed [15:0] r_speed_l;
    logic signed [15:0] r_speed_r;
    logic               r_trk_on;
    logic [1:0]         r_action;
    logic signed [15:0] r_dev;
    logic signed [15:0] r_base;
    logic signed [31:0] r_corr;
    logic signed [31:0] r_tgt_l;
    logic signed [31:0] r_tgt_r;

    logic               r_out_valid;
    logic signed [31:0] r_drive_l;
    logic signed [31:0] r_drive_r;
    logic signed [31:0] r_out_corr;

    t_trk_cmd           w_trk_cmd;
    t_lane_cmd          w_lane_cmd;
    logic               w_trk_done;
    logic signed [31:0] w_corr;
    logic [1:0]         w_lane_done;
    logic signed [31:0] w_last_l;
    logic signed [31:0] w_last_r;
    logic               w_load;
    logic signed [32:0] w_bpc;
    logic signed [32:0] w_bmc;
    logic signed [31:0] n_tgt_l;
    logic signed [31:0] n_tgt_r;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_gains <= '{kp: 16'd2048, ki: 16'd102, kd: 16'd4096};
            r_vel_limit <= 16'd1000;
            r_trk_gains <= '{kp: 16'd819, ki: 16'd20, kd: 16'd82};
            r_cen       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_VEL_KP:    r_vel_gains.kp <= i_cfg_data;
                REG_VEL_KI:    r_vel_gains.ki <= i_cfg_data;
                REG_VEL_KD:    r_vel_gains.kd <= i_cfg_data;
                REG_VEL_LIMIT: r_vel_limit    <= i_cfg_data;
                REG_TRK_KP:    r_trk_gains.kp <= i_cfg_data;
                REG_TRK_KI:    r_trk_gains.ki <= i_cfg_data;
                REG_TRK_KD:    r_trk_gains.kd <= i_cfg_data;
                REG_CTRL_EN:   r_cen          <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_load     = (r_state == S_PUT) && (!r_out_valid || i_out_ready);

    // wheel targets from the track correction
    always_comb begin
        w_bpc = 33'(r_base) + 33'(w_corr);
        w_bmc = 33'(r_base) - 33'(w_corr);
        case (r_action)
            ACT_TENDENCY: begin
                n_tgt_l = w_corr[31] ? f_sat32(w_bpc) : 32'(r_base);
                n_tgt_r = w_corr[31] ? 32'(r_base) : f_sat32(w_bmc);
            end
            ACT_TORQUE: begin
                n_tgt_l = f_sat32(w_bpc);
                n_tgt_r = f_sat32(w_bmc);
            end
            default: begin
                n_tgt_l = w_corr;
                n_tgt_r = f_sat32(-33'(w_corr));
            end
        endcase
    end

    // dispatch commands to the track unit and the lanes
    always_comb begin
        w_trk_cmd  = '0;
        w_lane_cmd = '0;
        if (r_state == S_DISP) begin
            if (r_op == OP_DECLINE) begin
                w_lane_cmd = '{start: 1'b1, op: LOP_DECLINE, ld: 1'b0};
            end else if (!r_cen) begin
                w_lane_cmd = '{start: 1'b1, op: LOP_CLEAR, ld: 1'b0};
            end else if (r_trk_on && r_action != ACT_STRAIGHT) begin
                w_trk_cmd = '{start: 1'b1, clr: 1'b0};
            end else begin
                w_trk_cmd  = '{start: 1'b1, clr: 1'b1};
                w_lane_cmd = '{start: 1'b1, op: LOP_RUN, ld: r_trk_on};
            end
        end else if (r_state == S_TGT) begin
            w_lane_cmd = '{start: 1'b1, op: LOP_RUN, ld: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op      <= i_operation;
                        r_speed_l <= i_speed_left;
                        r_speed_r <= i_speed_right;
                        r_trk_on  <= i_track_enable;
                        r_action  <= i_track_action;
                        r_dev     <= i_deviation_level;
                        r_base    <= i_base_target_speed;
                        // straight targets must be in place when the lanes start
                        r_corr    <= '0;
                        r_tgt_l   <= 32'(i_deviation_level);
                        r_tgt_r   <= 32'(i_deviation_level);
                        r_state   <= S_DISP;
                    end
                end
                S_DISP: begin
                    if (w_trk_cmd.start && !w_trk_cmd.clr)
                        r_state <= S_TRK;
                    else
                        r_state <= S_LANE;
                end
                S_TRK: begin
                    if (w_trk_done) begin
                        r_corr  <= w_corr;
                        r_tgt_l <= n_tgt_l;
                        r_tgt_r <= n_tgt_r;
                        r_state <= S_TGT;
                    end
                end
                S_TGT: r_state <= S_LANE;
                S_LANE: begin
                    if (w_lane_done[0])
                        r_state <= S_PUT;
                end
                S_PUT: begin
                    if (w_load) begin
                        r_drive_l  <= w_last_l;
                        r_drive_r  <= w_last_r;
                        r_out_corr <= r_corr;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ctvp_trk u_trk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_trk_cmd),
        .i_action (r_action),
        .i_dev    (r_dev),
        .i_gains  (r_trk_gains),
        .o_done   (w_trk_done),
        .o_corr   (w_corr)
    );

    ctvp_lane u_lane_l (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_lane_cmd),
        .i_target     (r_tgt_l),
        .i_speed      (r_speed_l),
        .i_gains      (r_vel_gains),
        .i_sum_limit  (r_vel_limit),
        .o_done       (w_lane_done[0]),
        .o_last_drive (w_last_l)
    );

    ctvp_lane u_lane_r (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_lane_cmd),
        .i_target     (r_tgt_r),
        .i_speed      (r_speed_r),
        .i_gains      (r_vel_gains),
        .i_sum_limit  (r_vel_limit),
        .o_done       (w_lane_done[1]),
        .o_last_drive (w_last_r)
    );

    assign o_out_valid        = r_out_valid;
    assign o_drive_left       = r_drive_l;
    assign o_drive_right      = r_drive_r;
    assign o_track_correction = r_out_corr;

`ifndef NO_ASSERTIONS
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_done[0] == w_lane_done[1])
        else $error("velocity lanes finished out of step");

    a_trk_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LANE) |-> !w_trk_done)
        else $error("track unit finished while lanes were running");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_op == OP_CONTROL && !r_cen) |=>
        (o_drive_left == 32'sd0 && o_drive_right == 32'sd0 && o_track_correction == 32'sd0))
        else $error("disabled control step gave non-zero output");

    a_decline_no_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_op == OP_DECLINE) |=> (o_track_correction == 32'sd0))
        else $error("decline transaction carried a track correction");
`endif

endmodule

@@ hw/rtl/ctvp_trk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctvp_trk
// Track PID: scaled deviation error, decaying clamped integral, and a
// multiply-accumulate of the P, I and D terms for the correction.
// ----------------------------------------------------------------------------
module ctvp_trk
    import ctvp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_trk_cmd            i_cmd,
    input  logic [1:0]          i_action,
    input  logic signed [15:0]  i_dev,
    input  t_gains              i_gains,
    output logic                o_done,
    output logic signed [31:0]  o_corr
);

    logic signed [TRK_E_W-1:0]  r_last_e;
    logic signed [SUM_W-1:0]    r_integ;
    logic signed [TRK_E_W-1:0]  r_e;
    logic signed [TRK_D_W-1:0]  r_d;
    logic signed [TRK_ACC_W-1:0] r_acc;
    logic [2:0]                 r_step;
    logic                       r_done;
    logic signed [31:0]         r_corr;

    logic signed [TRK_E_W-1:0]  w_coef;
    logic signed [TRK_E_W-1:0]  w_e;
    logic signed [TRK_D_W-1:0]  w_d;
    logic signed [TRK_D_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]    n_integ;
    logic signed [TRK_D_W-1:0]  w_opnd;
    logic [15:0]                w_gain;
    logic signed [TRK_ACC_W-1:0] w_prod;

    always_comb begin
        w_coef = (i_action == ACT_ROTATE) ? TRK_E_W'(ROTATE_COEF) : TRK_E_W'(CORRECTION_COEF);
        w_e    = TRK_E_W'(i_dev) * w_coef;
        w_d    = TRK_D_W'(w_e) - TRK_D_W'(r_last_e);
        w_sum  = TRK_D_W'(r_integ) + TRK_D_W'(w_e);
        if (w_e == '0)
            n_integ = f_decay(r_integ);
        else if (w_sum > TRK_D_W'(TRACK_SUM_LIMIT))
            n_integ = SUM_W'(TRACK_SUM_LIMIT);
        else if (w_sum < -TRK_D_W'(TRACK_SUM_LIMIT))
            n_integ = -SUM_W'(TRACK_SUM_LIMIT);
        else
            n_integ = w_sum[SUM_W-1:0];
    end

    always_comb begin
        case (r_step)
            3'd1: begin
                w_opnd = TRK_D_W'(r_e);
                w_gain = i_gains.kp;
            end
            3'd2: begin
                w_opnd = TRK_D_W'(r_integ);
                w_gain = i_gains.ki;
            end
            default: begin
                w_opnd = r_d;
                w_gain = i_gains.kd;
            end
        endcase
        w_prod = TRK_ACC_W'($signed({1'b0, w_gain})) * TRK_ACC_W'(w_opnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_e <= '0;
            r_integ  <= '0;
            r_step   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && i_cmd.clr) begin
                r_last_e <= '0;
                r_integ  <= '0;
            end else if (i_cmd.start) begin
                r_e      <= w_e;
                r_d      <= w_d;
                r_last_e <= w_e;
                r_integ  <= n_integ;
                r_step   <= 3'd1;
            end else begin
                case (r_step)
                    3'd1: begin
                        r_acc  <= w_prod;
                        r_step <= 3'd2;
                    end
                    3'd2: begin
                        r_acc  <= r_acc + w_prod;
                        r_step <= 3'd3;
                    end
                    3'd3: begin
                        r_acc  <= r_acc - w_prod;
                        r_step <= 3'd4;
                    end
                    3'd4: begin
                        r_corr <= f_scale_sat(ACC_W'(r_acc));
                        r_done <= 1'b1;
                        r_step <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_corr = r_corr;

endmodule

@@ hw/rtl/ctvp_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctvp_lane
// One wheel's velocity PID: error, clamped integral, last error, target and
// last drive, with a multiply-accumulate of the P, I and D terms.
// ----------------------------------------------------------------------------
module ctvp_lane
    import ctvp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_cmd           i_cmd,
    input  logic signed [31:0]  i_target,
    input  logic signed [15:0]  i_speed,
    input  t_gains              i_gains,
    input  logic [15:0]         i_sum_limit,
    output logic                o_done,
    output logic signed [31:0]  o_last_drive
);

    logic signed [31:0]         r_target;
    logic signed [VEL_E_W-1:0]  r_last_e;
    logic signed [SUM_W-1:0]    r_integ;
    logic signed [31:0]         r_last_drive;
    logic signed [VEL_E_W-1:0]  r_e;
    logic signed [VEL_D_W-1:0]  r_d;
    logic signed [ACC_W-1:0]    r_acc;
    logic [2:0]                 r_step;
    logic                       r_done;

    logic signed [31:0]         w_tgt;
    logic signed [VEL_E_W-1:0]  w_e;
    logic signed [VEL_D_W-1:0]  w_d;
    logic signed [VEL_D_W-1:0]  w_sum;
    logic signed [VEL_D_W-1:0]  w_lim;
    logic signed [SUM_W-1:0]    n_integ;
    logic signed [VEL_D_W-1:0]  w_opnd;
    logic [15:0]                w_gain;
    logic signed [ACC_W-1:0]    w_prod;

    always_comb begin
        w_tgt = i_cmd.ld ? i_target : r_target;
        w_e   = f_sat32(33'(w_tgt) - 33'(i_speed));
        w_d   = VEL_D_W'(w_e) - VEL_D_W'(r_last_e);
        w_sum = VEL_D_W'(r_integ) + VEL_D_W'(w_e);
        w_lim = $signed({17'd0, i_sum_limit});
        if (w_sum > w_lim)
            n_integ = w_lim[SUM_W-1:0];
        else if (w_sum < -w_lim)
            n_integ = -w_lim[SUM_W-1:0];
        else
            n_integ = w_sum[SUM_W-1:0];
    end

    always_comb begin
        case (r_step)
            3'd1: begin
                w_opnd = VEL_D_W'(r_e);
                w_gain = i_gains.kp;
            end
            3'd2: begin
                w_opnd = VEL_D_W'(r_integ);
                w_gain = i_gains.ki;
            end
            default: begin
                w_opnd = r_d;
                w_gain = i_gains.kd;
            end
        endcase
        w_prod = ACC_W'($signed({1'b0, w_gain})) * ACC_W'(w_opnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= '0;
            r_last_e     <= '0;
            r_integ      <= '0;
            r_last_drive <= '0;
            r_step       <= '0;
            r_done       <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                unique case (i_cmd.op)
                    LOP_RUN: begin
                        r_target <= w_tgt;
                        r_e      <= w_e;
                        r_d      <= w_d;
                        r_last_e <= w_e;
                        r_integ  <= n_integ;
                        r_step   <= 3'd1;
                    end
                    LOP_DECLINE: begin
                        r_integ <= f_decay(r_integ);
                        r_done  <= 1'b1;
                    end
                    LOP_CLEAR: begin
                        r_target     <= '0;
                        r_last_e     <= '0;
                        r_integ      <= '0;
                        r_last_drive <= '0;
                        r_done       <= 1'b1;
                    end
                    default: r_done <= 1'b1;
                endcase
            end else begin
                case (r_step)
                    3'd1: begin
                        r_acc  <= w_prod;
                        r_step <= 3'd2;
                    end
                    3'd2: begin
                        r_acc  <= r_acc + w_prod;
                        r_step <= 3'd3;
                    end
                    3'd3: begin
                        r_acc  <= r_acc - w_prod;
                        r_step <= 3'd4;
                    end
                    3'd4: begin
                        r_last_drive <= f_scale_sat(r_acc);
                        r_done       <= 1'b1;
                        r_step       <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_done       = r_done;
    assign o_last_drive = r_last_drive;

endmodule
